// ===== sv/fmcce_pkg.sv =====
package fmcce_pkg;

  localparam int ADDR_W = 25;
  localparam int SUM_W = 26;
  localparam int PROGRAM_BYTES = 128;
  localparam int BUF_AW = 7;

  localparam logic [7:0] CMD_ID = 8'h00;
  localparam logic [7:0] CMD_READ = 8'h52;
  localparam logic [7:0] CMD_PROGRAM = 8'hF2;
  localparam logic [7:0] CMD_ERASE = 8'hF1;
  localparam logic [7:0] CMD_STATUS = 8'h83;
  localparam logic [7:0] CMD_SIZE = 8'h85;
  localparam logic [7:0] CMD_CLR_STATUS = 8'h89;

  localparam logic [7:0] ID_HEAD = 8'h80;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [7:0] STATUS_RESET = 8'hC1;
  localparam logic [7:0] STATUS_ERR_BITS = 8'h18;
  localparam logic [7:0] STATUS_READY = 8'h01;
  localparam logic [8:0] PAGE_MASK = 9'h1FF;
  localparam logic [2:0] MB_RESET = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMT_RD,
    ST_CMT_WR,
    ST_ERASE
  } state_t;

  typedef struct packed {
    logic accept;
    logic rd_load;
    logic cnt_inc;
    logic clear_wr;
    logic erase_wr;
    logic commit_wr;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic start_commit;
    logic start_erase;
    logic clr_last;
    logic ers_last;
    logic cmt_last;
  } dp_sts_t;

endpackage

// ===== sv/fmcce_ram.sv =====
module fmcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

endmodule

// ===== sv/fmcce_ctrl.sv =====
module fmcce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fmcce_pkg::dp_sts_t sts,
  output fmcce_pkg::ctl_cmd_t cmd
);
  import fmcce_pkg::*;

  state_t state, state_next;
  logic out_valid_next;
  logic can_take;

  assign can_take = (state == ST_IDLE) && (!out_valid || !out_stall);
  assign in_stall = !can_take;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid && can_take) begin
          priority if (sts.is_read) state_next = ST_READ;
          else if (sts.start_commit) state_next = ST_CMT_RD;
          else if (sts.start_erase) state_next = ST_ERASE;
          else state_next = ST_IDLE;
        end
      end
      ST_READ: state_next = ST_IDLE;
      ST_CMT_RD: state_next = ST_CMT_WR;
      ST_CMT_WR: if (sts.cmt_last) state_next = ST_IDLE; else state_next = ST_CMT_RD;
      ST_ERASE: if (sts.ers_last) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.accept = in_valid && can_take;
    cmd.rd_load = (state == ST_READ);
    cmd.clear_wr = (state == ST_CLEAR);
    cmd.erase_wr = (state == ST_ERASE);
    cmd.commit_wr = (state == ST_CMT_WR);
    cmd.cnt_inc = cmd.clear_wr || cmd.erase_wr || cmd.commit_wr;
    out_valid_next = out_valid && out_stall;
    if ((cmd.accept && !sts.is_read) || cmd.rd_load) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/fmcce_dp.sv =====
module fmcce_dp #(
  parameter int IMAGE_ADDR_BITS = 19,
  parameter int SECTOR_BYTES = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  fmcce_pkg::ctl_cmd_t cmd,
  output fmcce_pkg::dp_sts_t  sts,
  input  logic                kind,
  input  logic [7:0]          data_in,
  output logic [7:0]          data_out,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_data
);
  import fmcce_pkg::*;

  localparam int AW = IMAGE_ADDR_BITS;
  localparam logic [SUM_W-1:0] DEPTH = SUM_W'(1) << AW;

  logic [7:0] command;
  logic [15:0] pos;
  logic [ADDR_W-1:0] target;
  logic [7:0] status;
  logic [2:0] megabits;
  logic [AW-1:0] cnt;
  logic [7:0] cmt_len;
  logic [AW-1:0] erase_base;

  logic [SUM_W-1:0] size_raw, size, size_m1, masked_full;
  logic [ADDR_W-1:0] t_new, t_step;
  logic [AW-1:0] masked;
  logic [15:0] n_full;
  logic [7:0] n8;
  logic [7:0] imm_out;
  logic exch;
  logic buf_we;
  logic [7:0] buf_q, img_q;
  logic img_we;
  logic [AW-1:0] img_waddr;
  logic [7:0] img_wdata;

  assign size_raw = SUM_W'(megabits) << 17;
  assign size = (size_raw > DEPTH) ? DEPTH : size_raw;
  assign size_m1 = size - SUM_W'(1);
  assign exch = !kind;

  // assemble the packed page/byte address
  always_comb begin
    unique case (pos)
      16'd1: t_new = {data_in, 17'b0};
      16'd2: t_new = target | {8'b0, data_in, 9'b0};
      16'd3: t_new = target | {16'b0, data_in[1:0], 7'b0};
      16'd4: t_new = target | {18'b0, data_in[6:0]};
      default: t_new = target;
    endcase
  end

  assign masked_full = {1'b0, t_new} & size_m1;
  assign masked = masked_full[AW-1:0];
  assign t_step = {t_new[ADDR_W-1:9], (t_new[8:0] + 9'd1) & PAGE_MASK};

  assign n_full = pos - 16'd5;
  assign n8 = (n_full > 16'(PROGRAM_BYTES)) ? 8'(PROGRAM_BYTES) : n_full[7:0];

  always_comb begin
    imm_out = IDLE_BYTE;
    if (exch && pos != 16'd0) begin
      unique case (command)
        CMD_ID: begin
          if (pos == 16'd1) imm_out = ID_HEAD;
          else imm_out = (pos[1:0] == 2'd1) ? {5'b0, megabits} : 8'h00;
        end
        CMD_SIZE: imm_out = pos[0] ? {5'b0, megabits} : 8'h00;
        CMD_STATUS: imm_out = status;
        default: imm_out = IDLE_BYTE;
      endcase
    end
  end

  always_comb begin
    sts.is_read = exch && command == CMD_READ && pos > 16'd1;
    sts.start_commit = kind && command == CMD_PROGRAM && pos >= 16'd5 && n8 != 8'd0
                       && ({1'b0, target} + SUM_W'(n8)) <= size;
    sts.start_erase = exch && command == CMD_ERASE && pos == 16'd2
                      && (SUM_W'(masked) + SUM_W'(SECTOR_BYTES)) <= size;
    sts.clr_last = (cnt == {AW{1'b1}});
    sts.ers_last = (cnt == AW'(SECTOR_BYTES - 1));
    sts.cmt_last = (cnt == AW'(cmt_len - 8'd1));
  end

  assign buf_we = cmd.accept && exch && command == CMD_PROGRAM && pos >= 16'd5;

  always_comb begin
    img_we = cmd.clear_wr || cmd.erase_wr || cmd.commit_wr;
    img_wdata = IDLE_BYTE;
    img_waddr = cnt;
    priority if (cmd.erase_wr) begin
      img_waddr = erase_base + cnt;
    end else if (cmd.commit_wr) begin
      img_waddr = target[AW-1:0] + cnt;
      img_wdata = buf_q;
    end else begin
      img_waddr = cnt;
    end
  end

  fmcce_ram #(.WIDTH(8), .DEPTH(PROGRAM_BYTES)) u_buf (
    .clk(clk), .we(buf_we), .waddr(n_full[BUF_AW-1:0]), .wdata(data_in),
    .raddr(cnt[BUF_AW-1:0]), .q(buf_q)
  );

  fmcce_ram #(.WIDTH(8), .DEPTH(1 << IMAGE_ADDR_BITS)) u_img (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
    .raddr(masked), .q(img_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept && !sts.is_read) data_out <= imm_out;
    else if (cmd.rd_load) data_out <= img_q;
    if (cmd.accept && kind) cmt_len <= n8;
    if (cmd.accept && sts.start_erase) erase_base <= masked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command <= 8'h00;
      pos <= 16'd0;
      target <= '0;
      status <= STATUS_RESET;
      megabits <= MB_RESET;
      cnt <= '0;
    end else begin
      if (cfg_we) megabits <= cfg_data;
      if (cmd.accept) cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + AW'(1);
      if (cmd.accept) begin
        if (kind) begin
          pos <= 16'd0;
          command <= 8'h00;
        end else begin
          if (pos != 16'hFFFF) pos <= pos + 16'd1;
          if (pos == 16'd0) begin
            command <= data_in;
            target <= '0;
            if (data_in == CMD_CLR_STATUS) status <= (status & ~STATUS_ERR_BITS) | STATUS_READY;
          end else begin
            unique case (command)
              CMD_READ: target <= (pos >= 16'd9) ? t_step : t_new;
              CMD_PROGRAM: target <= t_new;
              CMD_ERASE: if (pos <= 16'd2) target <= t_new;
              default: target <= target;
            endcase
          end
        end
      end
    end
  end

endmodule

// ===== sv/flash_memory_card_command_engine.sv =====
// Byte-serial memory card command engine. Each input item either exchanges
// one byte while chip select is held (kind 0) or releases chip select (kind 1);
// every item returns exactly one byte on the output channel. After reset the
// card image is swept to 0xFF one byte per cycle while input is stalled (cfg_we
// writes to megabits are taken). Afterwards a plain exchange or release is
// answered directly, an array read byte waits in a read state for the
// registered image read port, a sector erase writes SECTOR_BYTES bytes in the
// erase state and a page program commit on release alternates a buffer read
// and an image write per buffered byte, set by the single image write port and
// the registered buffer read. Only one item is in work at a time; the output
// register lets a new item enter while the previous result is being taken.
module flash_memory_card_command_engine #(
  parameter int IMAGE_ADDR_BITS = 19,
  parameter int SECTOR_BYTES = 8192
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] data_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_out,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data
);
  import fmcce_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t sts;

  // sequence the sweep, erase, commit and read wait
  fmcce_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  // hold command state, address, status, buffer and image
  fmcce_dp #(.IMAGE_ADDR_BITS(IMAGE_ADDR_BITS), .SECTOR_BYTES(SECTOR_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .kind(kind), .data_in(data_in),
    .data_out(data_out), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

endmodule
